/* hdl/dnr_pkg.sv */
// ---------------------------------------------------------------------------
// Decimal number recognizer package
// Character codes, the parse phase type, the stage and result structs, and
// the shared multiply-by-ten-and-add step.
// ---------------------------------------------------------------------------
package dnr_pkg;

   // Character codes that the parser tests for.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int unsigned ACC_W   = 64;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned RADIX   = 10;

   localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Parse phase, one-hot.
   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_INT   = 5'b00010,
      PH_FRAC  = 5'b00100,
      PH_TRAIL = 5'b01000,
      PH_REJ   = 5'b10000
   } phase_type;

   // Request held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_field;
   } stage_type;

   // One result as it leaves the parser.
   typedef struct packed {
      logic                valid_res;
      logic                negative;
      logic [ACC_W-1:0]    integer_value;
      logic [ACC_W-1:0]    fraction_value;
      logic [COUNT_W-1:0]  fraction_digits;
      logic                overflow;
   } result_type;

   // Output of the accumulate step: saturation flag and new value.
   typedef struct packed {
      logic             sat;
      logic [ACC_W-1:0] value;
   } acc_step_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_point(input logic [7:0] c);
      return (c == CHAR_DOT) || (c == CHAR_COMMA);
   endfunction

   // acc * 10 + digit as two shifted copies and an add; any carry into the
   // top four bits means the 64-bit result would not fit, so saturate.
   function automatic acc_step_type acc_digit(input logic [ACC_W-1:0] acc,
                                              input logic [7:0]       c);
      logic [3:0]       d;
      logic [ACC_W+3:0] wide;
      acc_step_type     r;
      d    = 4'(c - CHAR_ZERO);
      wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
      if (wide[ACC_W+3:ACC_W] != 4'd0) begin
         r.sat   = 1'b1;
         r.value = ACC_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = wide[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/dnr_in_reg.sv */
// ---------------------------------------------------------------------------
// Decimal number recognizer input register
// Captures one request per cycle unless the parser is held.
// ---------------------------------------------------------------------------
module dnr_in_reg import dnr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       req_empty_field,
   input  logic       hold,
   output stage_type  stage
);

   stage_type stage_ff;
   stage_type stage_in;

   // Load a new request whenever the stage is not held.
   always_comb begin
      stage_in = stage_ff;
      if (!hold) begin
         stage_in.valid       = req_valid;
         stage_in.char_code   = req_char_code;
         stage_in.last_char   = req_last_char;
         stage_in.empty_field = req_empty_field;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.char_code   <= stage_in.char_code;
      stage_ff.last_char   <= stage_in.last_char;
      stage_ff.empty_field <= stage_in.empty_field;
   end

   assign stage = stage_ff;

endmodule

/* hdl/dnr_parse.sv */
// ---------------------------------------------------------------------------
// Decimal number recognizer parser
// Holds the field state, advances it by one byte per consumed request and
// forms the result on the last byte of a field.
// ---------------------------------------------------------------------------
module dnr_parse import dnr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   input  logic       consume,
   output result_type result
);

   phase_type            phase_ff, phase_in, phase_nx;
   logic                 minus_ff, minus_in, minus_nx;
   logic [ACC_W-1:0]     int_acc_ff, int_acc_in, int_acc_nx;
   logic [ACC_W-1:0]     frac_acc_ff, frac_acc_in, frac_acc_nx;
   logic [COUNT_W-1:0]   frac_cnt_ff, frac_cnt_in, frac_cnt_nx;
   logic                 had_int_ff, had_int_in, had_int_nx;
   logic                 had_point_ff, had_point_in, had_point_nx;
   logic                 had_frac_ff, had_frac_in, had_frac_nx;
   logic                 sat_ff, sat_in, sat_nx;
   logic [7:0]           c;
   logic                 take_int;
   logic                 ok;
   acc_step_type         step;

   assign c = stage.char_code;

   // One shared accumulate step; the phase picks which accumulator it feeds.
   assign step = acc_digit((phase_ff == PH_FRAC) ? frac_acc_ff : int_acc_ff, c);

   // Bytes in the integer part (and a leading byte that is not a space or a sign) share one rule.
   assign take_int = (phase_ff == PH_INT) ||
                     ((phase_ff == PH_LEAD) && (c != CHAR_SPACE) &&
                      (c != CHAR_MINUS) && (c != CHAR_PLUS));

   // Next state after this byte.
   always_comb begin
      phase_nx     = phase_ff;
      minus_nx     = minus_ff;
      int_acc_nx   = int_acc_ff;
      frac_acc_nx  = frac_acc_ff;
      frac_cnt_nx  = frac_cnt_ff;
      had_int_nx   = had_int_ff;
      had_point_nx = had_point_ff;
      had_frac_nx  = had_frac_ff;
      sat_nx       = sat_ff;
      if (!stage.empty_field) begin
         if (take_int) begin
            priority if (is_point(c)) begin
               had_point_nx = 1'b1;
               phase_nx     = PH_FRAC;
            end else if (is_digit(c)) begin
               had_int_nx = 1'b1;
               int_acc_nx = step.value;
               sat_nx     = sat_ff | step.sat;
               phase_nx   = PH_INT;
            end else begin
               phase_nx = PH_REJ;
            end
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  // Only spaces and signs reach here.
                  if (c != CHAR_SPACE) begin
                     minus_nx = (c == CHAR_MINUS);
                     phase_nx = PH_INT;
                  end
               end
               PH_FRAC: begin
                  priority if (c == CHAR_SPACE) begin
                     phase_nx = PH_TRAIL;
                  end else if (is_digit(c)) begin
                     had_frac_nx = 1'b1;
                     frac_acc_nx = step.value;
                     if (frac_cnt_ff == COUNT_MAX) begin
                        sat_nx = 1'b1;
                     end else begin
                        frac_cnt_nx = frac_cnt_ff + 1'b1;
                     end
                     if (step.sat) begin
                        sat_nx = 1'b1;
                     end
                  end else begin
                     phase_nx = PH_REJ;
                  end
               end
               PH_TRAIL: begin
                  if (c != CHAR_SPACE) begin
                     phase_nx = PH_REJ;
                  end
               end
               default: begin
                  phase_nx = PH_REJ;
               end
            endcase
         end
      end
   end

   // The field's result; all fields read zero when it is not well formed.
   always_comb begin
      ok = (phase_nx != PH_REJ) && (had_int_nx || (had_point_nx && had_frac_nx));
      result.valid_res       = ok;
      result.negative        = ok & minus_nx;
      result.integer_value   = ok ? int_acc_nx : '0;
      result.fraction_value  = ok ? frac_acc_nx : '0;
      result.fraction_digits = ok ? frac_cnt_nx : '0;
      result.overflow        = ok & sat_nx;
   end

   // The state returns to its start values after the last byte of a field.
   always_comb begin
      phase_in     = phase_ff;
      minus_in     = minus_ff;
      int_acc_in   = int_acc_ff;
      frac_acc_in  = frac_acc_ff;
      frac_cnt_in  = frac_cnt_ff;
      had_int_in   = had_int_ff;
      had_point_in = had_point_ff;
      had_frac_in  = had_frac_ff;
      sat_in       = sat_ff;
      if (consume) begin
         if (stage.last_char) begin
            phase_in     = PH_LEAD;
            minus_in     = 1'b0;
            int_acc_in   = '0;
            frac_acc_in  = '0;
            frac_cnt_in  = '0;
            had_int_in   = 1'b0;
            had_point_in = 1'b0;
            had_frac_in  = 1'b0;
            sat_in       = 1'b0;
         end else begin
            phase_in     = phase_nx;
            minus_in     = minus_nx;
            int_acc_in   = int_acc_nx;
            frac_acc_in  = frac_acc_nx;
            frac_cnt_in  = frac_cnt_nx;
            had_int_in   = had_int_nx;
            had_point_in = had_point_nx;
            had_frac_in  = had_frac_nx;
            sat_in       = sat_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         minus_ff     <= 1'b0;
         int_acc_ff   <= '0;
         frac_acc_ff  <= '0;
         frac_cnt_ff  <= '0;
         had_int_ff   <= 1'b0;
         had_point_ff <= 1'b0;
         had_frac_ff  <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         int_acc_ff   <= int_acc_in;
         frac_acc_ff  <= frac_acc_in;
         frac_cnt_ff  <= frac_cnt_in;
         had_int_ff   <= had_int_in;
         had_point_ff <= had_point_in;
         had_frac_ff  <= had_frac_in;
         sat_ff       <= sat_in;
      end
   end

endmodule

/* hdl/dnr_out_reg.sv */
// ---------------------------------------------------------------------------
// Decimal number recognizer result register
// Holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
module dnr_out_reg import dnr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  result_type          result,
   input  logic                rsp_stall,
   output logic                full,
   output logic                rsp_valid,
   output logic                rsp_valid_res,
   output logic                rsp_negative,
   output logic [ACC_W-1:0]    rsp_integer_value,
   output logic [ACC_W-1:0]    rsp_fraction_value,
   output logic [COUNT_W-1:0]  rsp_fraction_digits,
   output logic                rsp_overflow
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // A new result may load in the same cycle the old one is taken.
   always_comb begin
      valid_in = valid_ff & rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign full                = valid_ff;
   assign rsp_valid           = valid_ff;
   assign rsp_valid_res       = data_ff.valid_res;
   assign rsp_negative        = data_ff.negative;
   assign rsp_integer_value   = data_ff.integer_value;
   assign rsp_fraction_value  = data_ff.fraction_value;
   assign rsp_fraction_digits = data_ff.fraction_digits;
   assign rsp_overflow        = data_ff.overflow;

endmodule

/* hdl/decimal_number_recognizer_top.sv */
// ---------------------------------------------------------------------------
// Decimal number recognizer
// Checks a text field, one byte per request, for a decimal number and
// reports sign, integer value, fraction value and fraction digit count.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake               Carries
//  req_*     in         req_valid / req_stall   one byte, last flag, no-byte flag
//  rsp_*     out        rsp_valid / rsp_stall   one result per field
//
// A request is parsed while it sits in the input register, and the result
// register loads at the next edge, so a field's result passes through the
// input register and then the result register; one request is taken every
// cycle while req_stall is low. The field state lives in one register set
// updated by a single multiply-by-ten-and-add step per byte.
// Reset is synchronous and returns the parser to the start of a field.
// Only a last request waiting behind an unread result holds the input.
// ---------------------------------------------------------------------------
module decimal_number_recognizer_top import dnr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_last_char,
   input  logic                req_empty_field,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_valid_res,
   output logic                rsp_negative,
   output logic [ACC_W-1:0]    rsp_integer_value,
   output logic [ACC_W-1:0]    rsp_fraction_value,
   output logic [COUNT_W-1:0]  rsp_fraction_digits,
   output logic                rsp_overflow
);

   stage_type  stage;
   result_type result;
   logic       full;
   logic       hold;
   logic       consume;

   // A last byte cannot be parsed while the result slot stays occupied.
   assign hold      = stage.valid & stage.last_char & full & rsp_stall;
   assign consume   = stage.valid & ~hold;
   assign req_stall = hold;

   dnr_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .req_empty_field (req_empty_field),
      .hold            (hold),
      .stage           (stage)
   );

   dnr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .consume (consume),
      .result  (result)
   );

   dnr_out_reg u_out_reg (
      .clock               (clock),
      .reset               (reset),
      .load                (consume & stage.last_char),
      .result              (result),
      .rsp_stall           (rsp_stall),
      .full                (full),
      .rsp_valid           (rsp_valid),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_negative        (rsp_negative),
      .rsp_integer_value   (rsp_integer_value),
      .rsp_fraction_value  (rsp_fraction_value),
      .rsp_fraction_digits (rsp_fraction_digits),
      .rsp_overflow        (rsp_overflow)
   );

endmodule

/* bench/decimal_number_recognizer_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decimal number recognizer checker
// Watches both channels of the recognizer. Every accepted request goes
// through a local parser, and a closing request queues the result it should
// produce. Each accepted result is compared field by field with the oldest
// queued result.
// ---------------------------------------------------------------------------
module decimal_number_recognizer_checker import dnr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_last_char,
   input  logic                req_empty_field,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_valid_res,
   input  logic                rsp_negative,
   input  logic [ACC_W-1:0]    rsp_integer_value,
   input  logic [ACC_W-1:0]    rsp_fraction_value,
   input  logic [COUNT_W-1:0]  rsp_fraction_digits,
   input  logic                rsp_overflow,
   output int unsigned         error_count,
   output int unsigned         pending_count,
   output int unsigned         request_count,
   output int unsigned         result_count,
   output int unsigned         number_count,
   output int unsigned         saturation_count
);

   // State of the field that is being parsed.
   phase_type           parse_phase;
   logic                minus_flag;
   logic [ACC_W-1:0]    int_acc;
   logic [ACC_W-1:0]    frac_acc;
   logic [COUNT_W-1:0]  frac_count;
   logic                got_int_digit;
   logic                got_point;
   logic                got_frac_digit;
   logic                got_sat;

   // Results owed by the block, oldest first.
   result_type          owed_results[$];

   // Clear the parser for a new field.
   task automatic start_field();
      parse_phase    = PH_LEAD;
      minus_flag     = 1'b0;
      int_acc        = '0;
      frac_acc       = '0;
      frac_count     = '0;
      got_int_digit  = 1'b0;
      got_point      = 1'b0;
      got_frac_digit = 1'b0;
      got_sat        = 1'b0;
   endtask

   // Shift one decimal digit into an accumulator, clamping at all ones.
   function automatic logic [ACC_W-1:0] shift_in_digit(input logic [ACC_W-1:0] acc,
                                                       input logic [7:0] c,
                                                       inout logic sat);
      logic [ACC_W-1:0] digit;
      digit = ACC_W'(c - CHAR_ZERO);
      if (acc > (ACC_MAX - digit) / RADIX) begin
         sat = 1'b1;
         return ACC_MAX;
      end
      return acc * RADIX + digit;
   endfunction

   // Advance the parser by one byte.
   task automatic absorb_byte(input logic [7:0] c);
      logic numeral;
      logic radix_mark;
      numeral    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      radix_mark = (c == CHAR_DOT) || (c == CHAR_COMMA);
      case (parse_phase)
         PH_LEAD, PH_INT: begin
            if (parse_phase == PH_LEAD && c == CHAR_SPACE) begin
               // Spaces ahead of the number are skipped.
            end else if (parse_phase == PH_LEAD && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
               minus_flag  = (c == CHAR_MINUS);
               parse_phase = PH_INT;
            end else if (radix_mark) begin
               got_point   = 1'b1;
               parse_phase = PH_FRAC;
            end else if (numeral) begin
               got_int_digit = 1'b1;
               int_acc       = shift_in_digit(int_acc, c, got_sat);
               parse_phase   = PH_INT;
            end else begin
               parse_phase = PH_REJ;
            end
         end
         PH_FRAC: begin
            if (c == CHAR_SPACE) begin
               parse_phase = PH_TRAIL;
            end else if (numeral) begin
               got_frac_digit = 1'b1;
               frac_acc       = shift_in_digit(frac_acc, c, got_sat);
               if (frac_count == COUNT_MAX) begin
                  got_sat = 1'b1;
               end else begin
                  frac_count = frac_count + 1'b1;
               end
            end else begin
               parse_phase = PH_REJ;
            end
         end
         PH_TRAIL: begin
            if (c != CHAR_SPACE) begin
               parse_phase = PH_REJ;
            end
         end
         default: begin
            parse_phase = PH_REJ;
         end
      endcase
   endtask

   // Compare one result field and count a mismatch.
   task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                              input logic [ACC_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Follow the requests, queue the owed results and check what comes out.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         start_field();
         owed_results.delete();
         error_count      = 0;
         request_count    = 0;
         result_count     = 0;
         number_count     = 0;
         saturation_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            request_count++;
            if (!req_empty_field) begin
               absorb_byte(req_char_code);
            end
            if (req_last_char) begin
               want = '0;
               if (parse_phase != PH_REJ &&
                   (got_int_digit || (got_point && got_frac_digit))) begin
                  want.valid_res       = 1'b1;
                  want.negative        = minus_flag;
                  want.integer_value   = int_acc;
                  want.fraction_value  = frac_acc;
                  want.fraction_digits = frac_count;
                  want.overflow        = got_sat;
               end
               owed_results.push_back(want);
               start_field();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("result arrived with no field closed");
               error_count++;
            end else begin
               want = owed_results.pop_front();
               result_count++;
               if (want.valid_res) begin
                  number_count++;
               end
               if (want.overflow) begin
                  saturation_count++;
               end
               check_field("valid_res", ACC_W'(want.valid_res), ACC_W'(rsp_valid_res));
               check_field("negative", ACC_W'(want.negative), ACC_W'(rsp_negative));
               check_field("integer_value", want.integer_value, rsp_integer_value);
               check_field("fraction_value", want.fraction_value, rsp_fraction_value);
               check_field("fraction_digits", ACC_W'(want.fraction_digits),
                           ACC_W'(rsp_fraction_digits));
               check_field("overflow", ACC_W'(want.overflow), ACC_W'(rsp_overflow));
            end
         end
      end
      pending_count = owed_results.size();
   end

endmodule

/* bench/decimal_number_recognizer_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decimal number recognizer test
// Feeds text fields to the recognizer: a directed set of corner cases, a
// burst that fills the block behind a held result channel, then random
// fields, mostly well-formed numbers with some broken ones. Both channels
// idle at random; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module decimal_number_recognizer_top_test;
   import dnr_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 150;
   localparam int unsigned QUIET_ITEMS  = 50;
   localparam int unsigned FILL_FIELDS  = 40;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_char_code;
   logic                req_last_char;
   logic                req_empty_field;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_valid_res;
   logic                rsp_negative;
   logic [ACC_W-1:0]    rsp_integer_value;
   logic [ACC_W-1:0]    rsp_fraction_value;
   logic [COUNT_W-1:0]  rsp_fraction_digits;
   logic                rsp_overflow;

   int unsigned         error_count;
   int unsigned         pending_count;
   int unsigned         request_count;
   int unsigned         result_count;
   int unsigned         number_count;
   int unsigned         saturation_count;

   // Shared between the sender and the receiver.
   bit                  quiet;
   bit                  hold_rsp;
   int unsigned         items_sent;
   int unsigned         cycle_count;
   logic [7:0]          field_bytes[$];

   decimal_number_recognizer_top u_top (.*);

   decimal_number_recognizer_checker u_checker (.*);

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Guard against a hung run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Result side: one long hold on request, random stall bursts otherwise.
   initial begin
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Offer one request and wait until it is taken.
   task automatic send_req(input logic [7:0] c, input logic last, input logic no_byte);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= c;
      req_last_char   <= last;
      req_empty_field <= no_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send the collected bytes as one field, with the odd byteless request
   // mixed in. A field may also be closed by a byteless last request.
   task automatic send_field(input bit close_empty);
      int n;
      n = field_bytes.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
         send_req(field_bytes[i], !close_empty && (i == n - 1), 1'b0);
         items_sent++;
      end
      if (close_empty) begin
         send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         items_sent++;
      end
      field_bytes.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         field_bytes.push_back(s[i]);
      end
   endtask

   task automatic directed(input string s, input bit close_empty);
      add_text(s);
      send_field(close_empty);
   endtask

   function automatic logic [7:0] any_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Build one random field: mostly well-formed numbers, some with one byte
   // spoiled, some made of number-like characters, some of arbitrary bytes.
   task automatic make_random_field(output bit close_empty);
      string       alphabet;
      int unsigned kind;
      int unsigned n;
      alphabet = " +-.,0123456789";
      kind     = $urandom_range(0, 15);
      if (kind < 10) begin
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
            field_bytes.push_back(CHAR_SPACE);
         end
         case ($urandom_range(0, 2))
            1: field_bytes.push_back(CHAR_PLUS);
            2: field_bytes.push_back(CHAR_MINUS);
            default: begin
            end
         endcase
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 5);
         repeat (n) field_bytes.push_back(any_digit());
         if ($urandom_range(0, 2) != 0) begin
            field_bytes.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 5);
            repeat (n) field_bytes.push_back(any_digit());
            repeat ($urandom_range(0, 2)) field_bytes.push_back(CHAR_SPACE);
         end
         // Spoil one byte of the number.
         if (kind == 9 && field_bytes.size() != 0) begin
            field_bytes[$urandom_range(0, field_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end else if (kind < 13) begin
         repeat ($urandom_range(1, 8)) begin
            field_bytes.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
         end
      end else if (kind < 15) begin
         repeat ($urandom_range(1, 6)) field_bytes.push_back(8'($urandom_range(0, 255)));
      end
      close_empty = (field_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
   endtask

   // Request side and verdict.
   initial begin : stimulus
      bit close_empty;
      quiet           = 1'b0;
      hold_rsp        = 1'b0;
      items_sent      = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_char_code   <= '0;
      req_last_char   <= 1'b0;
      req_empty_field <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Corner cases of the number format.
      directed("0", 0);
      directed("0123456789", 0);
      directed("18446744073709551615", 0);
      directed("18446744073709551616", 0);
      directed("-0", 0);
      directed("+42", 0);
      directed("  7", 0);
      directed("3.14", 0);
      directed("-2,50", 0);
      directed(".5", 0);
      directed("5.", 0);
      directed("5.  ", 0);
      directed("42", 1);
      directed("", 1);
      directed(".", 0);
      directed("-", 0);
      directed("   ", 0);
      directed("- 5", 0);
      directed("1 2", 0);
      directed("5 ", 0);
      directed("1.2.3", 0);
      directed("1.5 x", 0);
      directed("+-3", 0);
      field_bytes.push_back(8'h00);
      send_field(0);
      field_bytes.push_back(CHAR_NINE);
      field_bytes.push_back(8'hFF);
      send_field(0);
      // A fraction count right at its ceiling, then one digit past it.
      add_text(".");
      repeat (COUNT_MAX) field_bytes.push_back(CHAR_ZERO);
      send_field(0);
      add_text("-1.");
      repeat (COUNT_MAX + 1) field_bytes.push_back(CHAR_ZERO);
      send_field(0);

      // Hold the result channel while short fields keep coming.
      hold_rsp = 1'b1;
      repeat (FILL_FIELDS) begin
         field_bytes.push_back(any_digit());
         send_field(0);
      end

      // Let everything drain before the random part.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Random fields; the tail runs without idling.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent + QUIET_ITEMS >= RANDOM_ITEMS) begin
            quiet = 1'b1;
         end
         make_random_field(close_empty);
         send_field(close_empty);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d results.", request_count, result_count);
      $display("Of those, %0d were valid numbers and %0d saturated.",
               number_count, saturation_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
